/* rtl/tapr_pkg.sv */
package tapr_pkg;

    localparam int RAW_W     = 16;
    localparam int ID_W      = 11;
    localparam int CMD_W     = 8;
    localparam int LEN_W     = 4;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [RAW_W-1:0] HOME_RAW      = 16'd7500;
    localparam logic [CMD_W-1:0] REPLY_COMMAND = 8'd1;
    localparam logic [LEN_W-1:0] REPLY_LENGTH  = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE = 1'b1;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_REPLY
    } tapr_state_t;

endpackage

/* rtl/two_axis_timed_position_ramp.sv */
// tick: uses the shared bit-serial divider, which runs once per axis
// one transaction at a time; a read reply waits in an output register that, while stalled,
//   holds off the transaction after the next read request
// reset: positions and goals at 7500, duration and elapsed zero, node_id 8, command_code 1
module two_axis_timed_position_ramp #(
    parameter int AXES          = 2,
    parameter int FRACTION_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic                            on_channel_b,
    input  logic [tapr_pkg::ID_W-1:0]       frame_id,
    input  logic [tapr_pkg::CMD_W-1:0]      frame_command,
    input  logic                            is_remote,
    input  logic [tapr_pkg::RAW_W-1:0]      target_a,
    input  logic [tapr_pkg::RAW_W-1:0]      target_b,
    input  logic [tapr_pkg::TICK_W-1:0]     move_ticks,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tapr_pkg::ID_W-1:0]       reply_id,
    output logic [tapr_pkg::CMD_W-1:0]      reply_command,
    output logic [tapr_pkg::LEN_W-1:0]      reply_length,
    output logic [tapr_pkg::RAW_W-1:0]      position_a,
    output logic [tapr_pkg::RAW_W-1:0]      position_b,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tapr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tapr_pkg::ID_W-1:0]       cfg_data
);
    import tapr_pkg::*;

    localparam int PW     = RAW_W + FRACTION_BITS;
    localparam int MW     = PW + TICK_W;
    localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic [PW-1:0] HOME_FIX = PW'(HOME_RAW) << FRACTION_BITS;

    tapr_state_t state_reg, state_next;

    logic [PW-1:0]     cur_reg   [AXES];
    logic [PW-1:0]     cur_next  [AXES];
    logic [PW-1:0]     start_reg [AXES];
    logic [PW-1:0]     start_next[AXES];
    logic [RAW_W-1:0]  goal_reg  [AXES];
    logic [RAW_W-1:0]  goal_next [AXES];
    logic [TICK_W-1:0] dur_reg, dur_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [ID_W-1:0]   node_id_reg, node_id_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [MW-1:0]     prod_reg, prod_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   reply_id_reg, reply_id_next;
    logic [RAW_W-1:0]  pos_a_reg, pos_a_next;
    logic [RAW_W-1:0]  pos_b_reg, pos_b_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              mul_done_reg;

    logic              accept;
    logic              match;
    logic              out_free;
    logic              load_out;
    logic [RAW_W-1:0]  raw_a;
    logic [RAW_W-1:0]  raw_b;
    logic [PW-1:0]     s_sel;
    logic [PW-1:0]     g_fix;
    logic              ramp_up;
    logic [PW-1:0]     diff_mag;
    logic [PW-1:0]     new_pos;
    logic              div_start;
    logic              div_done;
    logic [MW-1:0]     div_q;

    tapr_div #(
        .DVD_W(MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign raw_a = cur_reg[0][PW-1:FRACTION_BITS];

    generate
        if (AXES > 1)
        begin : g_axis_b
            assign raw_b = cur_reg[1][PW-1:FRACTION_BITS];
        end
        else
        begin : g_home_b
            assign raw_b = HOME_RAW;
        end
    endgenerate

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign match     = on_channel_b && (frame_id == node_id_reg) && (frame_command == cmd_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // per-axis ramp datapath, truncating toward zero on the magnitude
    assign s_sel    = start_reg[axis_reg];
    assign g_fix    = PW'(goal_reg[axis_reg]) << FRACTION_BITS;
    assign ramp_up  = (g_fix >= s_sel);
    assign diff_mag = ramp_up ? (g_fix - s_sel) : (s_sel - g_fix);
    assign new_pos  = neg_reg ? (s_sel - div_q[PW-1:0]) : (s_sel + div_q[PW-1:0]);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        dur_next     = dur_reg;
        elapsed_next = elapsed_reg;
        axis_next    = axis_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        pend_id_next = pend_id_reg;
        div_start    = 1'b0;
        load_out     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_TICK)
                    begin
                        if (dur_reg == '0)
                        begin
                            cur_next = start_reg;
                        end
                        else
                        begin
                            axis_next  = '0;
                            state_next = S_MUL;
                        end
                    end
                    else if (match)
                    begin
                        if (!is_remote)
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                start_next[i] = cur_reg[i];
                                if (i == 0)
                                    goal_next[i] = target_a;
                                else if (i == 1)
                                    goal_next[i] = target_b;
                                else
                                    goal_next[i] = HOME_RAW;
                            end
                            dur_next     = move_ticks;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            pend_id_next = frame_id;
                            if (out_free)
                                load_out = 1'b1;
                            else
                                state_next = S_REPLY;
                        end
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = MW'(diff_mag) * MW'(elapsed_reg);
                neg_next   = !ramp_up;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cur_next[axis_reg] = new_pos;
                    if (axis_reg == AXIS_W'(AXES - 1))
                    begin
                        if (elapsed_reg < dur_reg)
                            elapsed_next = elapsed_reg + TICK_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = S_MUL;
                    end
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // divider is started in the first S_DIV cycle, once the product is in prod_reg
        if (state_reg == S_DIV && mul_done_reg)
            div_start = 1'b1;
    end

    // divider start pulse, raised in the cycle in which the product lands in prod_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_done_reg <= 1'b0;
        else
            mul_done_reg <= (state_reg == S_MUL);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        reply_id_next  = reply_id_reg;
        pos_a_next     = pos_a_reg;
        pos_b_next     = pos_b_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            reply_id_next  = (state_reg == S_REPLY) ? pend_id_reg : frame_id;
            pos_a_next     = raw_a;
            pos_b_next     = raw_b;
        end
    end

    always_comb
    begin
        node_id_next = node_id_reg;
        cmd_next     = cmd_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NODE_ID:      node_id_next = cfg_data;
                CFG_COMMAND_CODE: cmd_next     = cfg_data[CMD_W-1:0];
                default:          node_id_next = node_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                cur_reg[i]   <= HOME_FIX;
                start_reg[i] <= HOME_FIX;
                goal_reg[i]  <= HOME_RAW;
            end
            dur_reg       <= '0;
            elapsed_reg   <= '0;
            node_id_reg   <= ID_W'(8);
            cmd_reg       <= CMD_W'(1);
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            goal_reg      <= goal_next;
            dur_reg       <= dur_next;
            elapsed_reg   <= elapsed_next;
            node_id_reg   <= node_id_next;
            cmd_reg       <= cmd_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        pend_id_reg  <= pend_id_next;
        reply_id_reg <= reply_id_next;
        pos_a_reg    <= pos_a_next;
        pos_b_reg    <= pos_b_next;
    end

    assign out_valid     = out_valid_reg;
    assign reply_id      = reply_id_reg;
    assign reply_command = REPLY_COMMAND;
    assign reply_length  = REPLY_LENGTH;
    assign position_a    = pos_a_reg;
    assign position_b    = pos_b_reg;

endmodule

/* rtl/tapr_div.sv */
module tapr_div #(
    parameter int DVD_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DVD_W-1:0]              dividend,
    input  logic [tapr_pkg::TICK_W-1:0]   divisor,
    output logic                          done,
    output logic [DVD_W-1:0]              quotient
);
    import tapr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [TICK_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   trial_sub;
    logic              q_bit;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign q_bit     = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, shifted into the dividend register
            dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
            rem_next = q_bit ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
